// ===== hdl/lz4d_pkg.sv =====
package lz4d_pkg;

  localparam int WINDOW_LOG2_DEFAULT = 16;
  localparam int LEN_BITS_DEFAULT    = 32;

  // Token nibble value that announces extension bytes, and the extension byte
  // value that announces yet another extension byte.
  localparam logic [3:0] NIBBLE_EXT   = 4'd15;
  localparam logic [7:0] LEN_EXT_BYTE = 8'd255;
  localparam logic [3:0] MIN_MATCH    = 4'd4;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_BAD_OFFSET = 2'd1;
  localparam logic [1:0] ERR_TRUNCATED  = 2'd2;
  localparam logic [1:0] ERR_UNEXPECTED = 2'd3;

  typedef struct packed {
    logic       emit;
    logic       from_hist;
    logic [7:0] lit_byte;
    logic       copy_pending;
    logic       block_done;
    logic [1:0] error_code;
  } lz4d_step_t;

endpackage

// ===== hdl/lz4d_if.sv =====
interface lz4d_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] in_byte;
  logic       block_end;

  modport source (output valid, output opcode, output in_byte, output block_end,
                  input ready);
  modport sink (input valid, input opcode, input in_byte, input block_end,
                output ready);
endinterface

interface lz4d_out_if;
  logic       valid;
  logic       ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       copy_pending;
  logic       block_done;
  logic [1:0] error_code;

  modport source (output valid, output out_valid, output out_byte,
                  output copy_pending, output block_done, output error_code,
                  input ready);
  modport sink (input valid, input out_valid, input out_byte,
                input copy_pending, input block_done, input error_code,
                output ready);
endinterface

// ===== hdl/lz4d_hist.sv =====
module lz4d_hist
  import lz4d_pkg::*;
#(
  parameter int WINDOW_LOG2 = WINDOW_LOG2_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   rd_en,
  input  logic [WINDOW_LOG2-1:0] rd_addr,
  input  logic                   wr_en,
  input  logic [WINDOW_LOG2-1:0] wr_addr,
  input  logic [7:0]             wr_data,
  output logic [7:0]             rd_data
);

  localparam int DEPTH = 1 << WINDOW_LOG2;

  logic [7:0] mem [DEPTH];
  logic [7:0] mem_q;
  logic [7:0] fwd_data;
  logic       fwd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q    <= mem[rd_addr];
      fwd_data <= wr_data;
    end
  end

  // A read that hits the entry being written in the same cycle sees the old
  // contents in the array, so the new byte is bypassed instead.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (rd_en) begin
      fwd <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd ? fwd_data : mem_q;

endmodule

// ===== hdl/lz4d_parser.sv =====
module lz4d_parser
  import lz4d_pkg::*;
#(
  parameter int WINDOW_LOG2 = WINDOW_LOG2_DEFAULT,
  parameter int LEN_BITS    = LEN_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic                   opcode,
  input  logic [7:0]             in_byte,
  input  logic                   block_end,
  output lz4d_step_t             step,
  output logic [WINDOW_LOG2-1:0] rd_addr,
  output logic [WINDOW_LOG2-1:0] wr_addr
);

  localparam logic [2:0] PH_TOKEN   = 3'd0;
  localparam logic [2:0] PH_LITLEN  = 3'd1;
  localparam logic [2:0] PH_LITERAL = 3'd2;
  localparam logic [2:0] PH_OFF_LO  = 3'd3;
  localparam logic [2:0] PH_OFF_HI  = 3'd4;
  localparam logic [2:0] PH_MATLEN  = 3'd5;
  localparam logic [2:0] PH_COPY    = 3'd6;
  localparam logic [2:0] PH_END     = 3'd7;

  localparam logic [WINDOW_LOG2:0] WIN_SIZE = (WINDOW_LOG2+1)'(1) << WINDOW_LOG2;
  localparam logic [LEN_BITS-1:0]  LEN_MAX  = '1;

  logic [2:0]             phase, phase_next;
  logic [WINDOW_LOG2-1:0] wp, wp_next;
  logic [WINDOW_LOG2:0]   produced, produced_next;
  logic [LEN_BITS-1:0]    lit_rem, lit_rem_next;
  logic [LEN_BITS-1:0]    mat_rem, mat_rem_next;
  logic [3:0]             nibble, nibble_next;
  logic [15:0]            offset, offset_next;

  logic [LEN_BITS:0]      len_sum;
  logic [LEN_BITS-1:0]    len_sat;
  logic [LEN_BITS-1:0]    lit_dec;
  logic [15:0]            off_full;
  logic [7:0]             len_addend;

  always_comb begin
    // Shared saturating adder for both extended lengths. On a match length
    // byte that ends the extension, the minimum match is folded in.
    len_addend = 8'd0;
    if (phase == PH_MATLEN && !block_end && in_byte != LEN_EXT_BYTE) begin
      len_addend = {4'd0, MIN_MATCH};
    end
    len_sum = (phase == PH_LITLEN) ? {1'b0, lit_rem} : {1'b0, mat_rem};
    len_sum = len_sum + (LEN_BITS+1)'(in_byte) + (LEN_BITS+1)'(len_addend);
    len_sat = len_sum[LEN_BITS] ? LEN_MAX : len_sum[LEN_BITS-1:0];
    lit_dec = (lit_rem != '0) ? lit_rem - 1'b1 : lit_rem;
    off_full = {in_byte, offset[7:0]};
  end

  always_comb begin
    phase_next    = phase;
    wp_next       = wp;
    produced_next = produced;
    lit_rem_next  = lit_rem;
    mat_rem_next  = mat_rem;
    nibble_next   = nibble;
    offset_next   = offset;
    step          = '0;
    step.error_code = ERR_NONE;
    rd_addr       = wp - offset[WINDOW_LOG2-1:0];
    wr_addr       = wp;

    if (phase == PH_END) begin
      step.error_code = ERR_UNEXPECTED;
    end else if (opcode) begin
      if (phase != PH_COPY) begin
        step.error_code = ERR_UNEXPECTED;
      end else begin
        step.emit      = 1'b1;
        step.from_hist = 1'b1;
        mat_rem_next   = mat_rem - 1'b1;
        if (mat_rem == LEN_BITS'(1)) begin
          phase_next = PH_TOKEN;
        end
      end
    end else begin
      unique case (phase)
        PH_TOKEN: begin
          nibble_next  = in_byte[3:0];
          lit_rem_next = LEN_BITS'(in_byte[7:4]);
          if (block_end) begin
            phase_next = PH_END;
            if (in_byte[7:4] != 4'd0) begin
              step.error_code = ERR_TRUNCATED;
            end
          end else if (in_byte[7:4] == NIBBLE_EXT) begin
            phase_next = PH_LITLEN;
          end else if (in_byte[7:4] != 4'd0) begin
            phase_next = PH_LITERAL;
          end else begin
            phase_next = PH_OFF_LO;
          end
        end
        PH_LITLEN: begin
          lit_rem_next = len_sat;
          if (block_end) begin
            phase_next      = PH_END;
            step.error_code = ERR_TRUNCATED;
          end else if (in_byte != LEN_EXT_BYTE) begin
            phase_next = PH_LITERAL;
          end
        end
        PH_LITERAL: begin
          step.emit     = 1'b1;
          step.lit_byte = in_byte;
          lit_rem_next  = lit_dec;
          if (lit_dec == '0) begin
            phase_next = block_end ? PH_END : PH_OFF_LO;
          end else if (block_end) begin
            phase_next      = PH_END;
            step.error_code = ERR_TRUNCATED;
          end
        end
        PH_OFF_LO: begin
          offset_next = {8'd0, in_byte};
          if (block_end) begin
            phase_next      = PH_END;
            step.error_code = ERR_TRUNCATED;
          end else begin
            phase_next = PH_OFF_HI;
          end
        end
        PH_OFF_HI: begin
          offset_next = off_full;
          if (block_end) begin
            phase_next      = PH_END;
            step.error_code = ERR_TRUNCATED;
          end else if (off_full == 16'd0 || 17'(off_full) > 17'(produced)) begin
            phase_next      = PH_END;
            step.error_code = ERR_BAD_OFFSET;
          end else if (nibble == NIBBLE_EXT) begin
            mat_rem_next = LEN_BITS'(NIBBLE_EXT);
            phase_next   = PH_MATLEN;
          end else begin
            mat_rem_next = LEN_BITS'(nibble) + LEN_BITS'(MIN_MATCH);
            phase_next   = PH_COPY;
          end
        end
        PH_MATLEN: begin
          mat_rem_next = len_sat;
          if (block_end) begin
            phase_next      = PH_END;
            step.error_code = ERR_TRUNCATED;
          end else if (in_byte != LEN_EXT_BYTE) begin
            phase_next = PH_COPY;
          end
        end
        default: begin
          step.error_code = ERR_UNEXPECTED;
        end
      endcase
    end

    if (step.emit) begin
      wp_next = wp + 1'b1;
      if (produced != WIN_SIZE) begin
        produced_next = produced + 1'b1;
      end
    end

    step.copy_pending = (phase_next == PH_COPY);
    step.block_done   = (phase_next == PH_END);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_TOKEN;
      wp       <= '0;
      produced <= '0;
      lit_rem  <= '0;
      mat_rem  <= '0;
      nibble   <= '0;
      offset   <= '0;
    end else if (accept) begin
      phase    <= phase_next;
      wp       <= wp_next;
      produced <= produced_next;
      lit_rem  <= lit_rem_next;
      mat_rem  <= mat_rem_next;
      nibble   <= nibble_next;
      offset   <= offset_next;
    end
  end

endmodule

// ===== hdl/lz4_block_decompressor_top.sv =====
// LZ4 block decompressor. Each input transaction carries one compressed byte
// or a drain request and produces exactly one output transaction, so the
// block sustains one item per clock cycle while downstream is ready. The
// parser decides the item and issues a history read on accepting it; the byte
// is formed in the middle stage and registered in the output stage. Recent
// output is kept in a 2^WINDOW_LOG2 by 8-bit history memory with one write
// and one registered read port; a match at offset one can read the byte still
// being written and takes it through a bypass. The history needs no clearing
// after reset, as offsets are checked against the number of bytes produced.
// Once decoding stops, on success or on an error, only reset starts a new block.
module lz4_block_decompressor_top
  import lz4d_pkg::*;
#(
  parameter int WINDOW_LOG2 = WINDOW_LOG2_DEFAULT,
  parameter int LEN_BITS    = LEN_BITS_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  lz4d_in_if.sink   upstream,
  lz4d_out_if.source downstream
);

  lz4d_step_t             step;
  logic [WINDOW_LOG2-1:0] rd_addr;
  logic [WINDOW_LOG2-1:0] wr_addr;
  logic                   accept;

  lz4d_step_t             s1_step;
  logic [WINDOW_LOG2-1:0] s1_wr_addr;
  logic                   s1_valid;
  logic                   s1_move;
  logic [7:0]             s1_byte;
  logic [7:0]             hist_data;

  logic                   o_valid;
  logic                   o_out_valid;
  logic [7:0]             o_byte;
  logic                   o_copy_pending;
  logic                   o_block_done;
  logic [1:0]             o_error_code;

  assign s1_move         = s1_valid && (!o_valid || downstream.ready);
  assign upstream.ready  = !s1_valid || s1_move;
  assign accept          = upstream.valid && upstream.ready;

  lz4d_parser #(
    .WINDOW_LOG2(WINDOW_LOG2),
    .LEN_BITS   (LEN_BITS)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .opcode   (upstream.opcode),
    .in_byte  (upstream.in_byte),
    .block_end(upstream.block_end),
    .step     (step),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr)
  );

  always_comb begin
    if (!s1_step.emit) begin
      s1_byte = 8'd0;
    end else if (s1_step.from_hist) begin
      s1_byte = hist_data;
    end else begin
      s1_byte = s1_step.lit_byte;
    end
  end

  // The history is written when the byte leaves the middle stage; a read
  // issued in the same cycle is the only one that can overlap it.
  lz4d_hist #(
    .WINDOW_LOG2(WINDOW_LOG2)
  ) u_hist (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept && step.from_hist),
    .rd_addr(rd_addr),
    .wr_en  (s1_move && s1_step.emit),
    .wr_addr(s1_wr_addr),
    .wr_data(s1_byte),
    .rd_data(hist_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_step    <= step;
      s1_wr_addr <= wr_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_move) begin
      o_valid <= 1'b1;
    end else if (downstream.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      o_out_valid    <= s1_step.emit;
      o_byte         <= s1_byte;
      o_copy_pending <= s1_step.copy_pending;
      o_block_done   <= s1_step.block_done;
      o_error_code   <= s1_step.error_code;
    end
  end

  assign downstream.valid        = o_valid;
  assign downstream.out_valid    = o_out_valid;
  assign downstream.out_byte     = o_byte;
  assign downstream.copy_pending = o_copy_pending;
  assign downstream.block_done   = o_block_done;
  assign downstream.error_code   = o_error_code;

endmodule

// ===== verif/testbench.sv =====
module testbench;
  import lz4d_pkg::*;

  localparam int WL          = WINDOW_LOG2_DEFAULT;
  localparam int LEN_W       = LEN_BITS_DEFAULT;
  localparam int WIN_SIZE    = 1 << WL;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam int END_NORMAL     = 0;
  localparam int END_ZERO_DIST  = 1;
  localparam int END_FAR_DIST   = 2;
  localparam int END_TRUNCATION = 3;

  typedef enum logic [2:0] {
    S_TOKEN, S_LIT_LEN, S_LITERAL, S_OFS_LO, S_OFS_HI, S_MATCH_LEN, S_COPY, S_STOPPED
  } parse_state_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       copy_pending;
    logic       block_done;
    logic [1:0] error_code;
  } dec_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lz4d_in_if  upstream ();
  lz4d_out_if downstream ();

  lz4_block_decompressor_top dut (
    .clk        (clk),
    .rst        (rst),
    .upstream   (upstream),
    .downstream (downstream)
  );

  always #1 clk = ~clk;

  // Decoder mirror: history window, counters and parse state.
  logic [7:0]       hist_mem [0:WIN_SIZE-1];
  logic [WL-1:0]    hist_wr = '0;
  logic [WL:0]      out_count = '0;
  parse_state_t     dec_state = S_TOKEN;
  logic [LEN_W-1:0] lits_left = '0;
  logic [LEN_W-1:0] copy_left = '0;
  logic [3:0]       match_nib = '0;
  logic [15:0]      match_dist = '0;

  dec_result_t decoded_q [$];
  logic [7:0]  seq_bytes [$];

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int fail_count = 0;
  int stream_items = 0;
  int bytes_out = 0;
  int flag_count [0:3] = '{0, 0, 0, 0};
  string end_kind = "none";

  function automatic logic [LEN_W-1:0] len_add(logic [LEN_W-1:0] a, logic [7:0] inc);
    logic [LEN_W:0] s;
    s = {1'b0, a} + (LEN_W+1)'(inc);
    return s[LEN_W] ? '1 : s[LEN_W-1:0];
  endfunction

  function automatic void record_byte(logic [7:0] v);
    hist_mem[hist_wr] = v;
    hist_wr = hist_wr + 1'b1;
    if (out_count < WIN_SIZE) out_count = out_count + 1'b1;
  endfunction

  function automatic dec_result_t decode_step(logic op, logic [7:0] b, logic is_last);
    dec_result_t   r;
    logic [WL-1:0] rd_idx;
    logic [7:0]    v;
    r = '0;
    if (dec_state == S_STOPPED) begin
      r.error_code = ERR_UNEXPECTED;
    end else if (op == OP_DRAIN) begin
      if (dec_state != S_COPY) begin
        r.error_code = ERR_UNEXPECTED;
      end else begin
        rd_idx = hist_wr - match_dist[WL-1:0];
        v = hist_mem[rd_idx];
        record_byte(v);
        r.out_valid = 1'b1;
        r.out_byte = v;
        copy_left = copy_left - 1'b1;
        if (copy_left == 0) dec_state = S_TOKEN;
      end
    end else begin
      case (dec_state)
        S_TOKEN: begin
          match_nib = b[3:0];
          lits_left = LEN_W'(b[7:4]);
          if (b[7:4] == NIBBLE_EXT) dec_state = S_LIT_LEN;
          else if (b[7:4] != 0) dec_state = S_LITERAL;
          else dec_state = S_OFS_LO;
          if (is_last) begin
            dec_state = S_STOPPED;
            if (b[7:4] != 0) r.error_code = ERR_TRUNCATED;
          end
        end
        S_LIT_LEN: begin
          lits_left = len_add(lits_left, b);
          if (is_last) begin
            dec_state = S_STOPPED;
            r.error_code = ERR_TRUNCATED;
          end else if (b != LEN_EXT_BYTE) begin
            dec_state = S_LITERAL;
          end
        end
        S_LITERAL: begin
          record_byte(b);
          r.out_valid = 1'b1;
          r.out_byte = b;
          if (lits_left != 0) lits_left = lits_left - 1'b1;
          if (lits_left == 0) begin
            dec_state = is_last ? S_STOPPED : S_OFS_LO;
          end else if (is_last) begin
            dec_state = S_STOPPED;
            r.error_code = ERR_TRUNCATED;
          end
        end
        S_OFS_LO: begin
          match_dist = {8'h00, b};
          if (is_last) begin
            dec_state = S_STOPPED;
            r.error_code = ERR_TRUNCATED;
          end else begin
            dec_state = S_OFS_HI;
          end
        end
        S_OFS_HI: begin
          match_dist[15:8] = b;
          if (is_last) begin
            dec_state = S_STOPPED;
            r.error_code = ERR_TRUNCATED;
          end else if (match_dist == 0 || match_dist > out_count) begin
            dec_state = S_STOPPED;
            r.error_code = ERR_BAD_OFFSET;
          end else if (match_nib == NIBBLE_EXT) begin
            copy_left = LEN_W'(NIBBLE_EXT);
            dec_state = S_MATCH_LEN;
          end else begin
            copy_left = len_add(LEN_W'(match_nib), 8'(MIN_MATCH));
            dec_state = S_COPY;
          end
        end
        S_MATCH_LEN: begin
          copy_left = len_add(copy_left, b);
          if (is_last) begin
            dec_state = S_STOPPED;
            r.error_code = ERR_TRUNCATED;
          end else if (b != LEN_EXT_BYTE) begin
            copy_left = len_add(copy_left, 8'(MIN_MATCH));
            dec_state = S_COPY;
          end
        end
        default: r.error_code = ERR_UNEXPECTED;
      endcase
    end
    r.copy_pending = (dec_state == S_COPY);
    r.block_done = (dec_state == S_STOPPED);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("cycle %0d: mismatch: %s", cycle_count, what);
    fail_count++;
  endtask

  // Each transaction leaves valid high; a gap or a drain lowers it first.
  task automatic send_item(input logic op, input logic [7:0] b, input logic is_last);
    while ($urandom_range(0, 99) < idle_pct) begin
      upstream.valid <= 1'b0;
      @(posedge clk);
    end
    upstream.valid     <= 1'b1;
    upstream.opcode    <= op;
    upstream.in_byte   <= b;
    upstream.block_end <= is_last;
    @(posedge clk);
    while (!upstream.ready) @(posedge clk);
    decoded_q.push_back(decode_step(op, b, is_last));
  endtask

  task automatic wait_drained();
    upstream.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  task automatic push_len_ext(input int extra);
    while (extra >= 255) begin
      seq_bytes.push_back(LEN_EXT_BYTE);
      extra -= 255;
    end
    seq_bytes.push_back(extra[7:0]);
  endtask

  // Compressed bytes of one sequence: token, length extensions, literals and,
  // if asked, the offset and the match length extensions.
  task automatic build_sequence(input int lit_n, input int match_n, input int distance,
                                input bit with_match);
    logic [3:0] lit_nib;
    logic [3:0] m_nib;
    int         mcode;
    mcode = match_n - 4;
    lit_nib = (lit_n >= 15) ? 4'd15 : lit_n[3:0];
    m_nib = (mcode >= 15) ? 4'd15 : mcode[3:0];
    seq_bytes.delete();
    seq_bytes.push_back({lit_nib, m_nib});
    if (lit_nib == NIBBLE_EXT) push_len_ext(lit_n - 15);
    repeat (lit_n) seq_bytes.push_back(8'($urandom_range(0, 255)));
    if (with_match) begin
      seq_bytes.push_back(distance[7:0]);
      seq_bytes.push_back(distance[15:8]);
      if (m_nib == NIBBLE_EXT) push_len_ext(mcode - 15);
    end
  endtask

  function automatic int pick_distance(int avail);
    if (avail > 65535) avail = 65535;
    case ($urandom_range(0, 3))
      0: return 1;
      1: return $urandom_range(1, (avail < 16) ? avail : 16);
      2: return avail;
      default: return $urandom_range(1, avail);
    endcase
  endfunction

  // Noise transactions are ones the decoder rejects without a state change.
  task automatic send_sequence(input int lit_n, input int match_n, input int noise_pct);
    int avail;
    if (out_count == 0 && lit_n == 0) lit_n = 1;
    avail = out_count + lit_n;
    build_sequence(lit_n, match_n, pick_distance(avail), 1'b1);
    foreach (seq_bytes[i]) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_item(OP_DRAIN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      send_item(OP_BYTE, seq_bytes[i], 1'b0);
      stream_items++;
    end
    repeat (match_n) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_item(OP_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      send_item(OP_DRAIN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      stream_items++;
    end
  endtask

  task automatic send_random_sequence(input int noise_pct);
    int lit_n;
    int match_n;
    lit_n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 30) : $urandom_range(0, 6);
    match_n = ($urandom_range(0, 9) == 0) ? $urandom_range(19, 30) : $urandom_range(4, 12);
    send_sequence(lit_n, match_n, noise_pct);
  endtask

  task automatic test_directed();
    // Drain with nothing pending, then a two-literal run and an offset-one
    // match that reads the byte just written.
    send_item(OP_DRAIN, 8'h5A, 1'b1);
    send_item(OP_BYTE, 8'h20, 1'b0);
    send_item(OP_BYTE, 8'h00, 1'b0);
    send_item(OP_BYTE, 8'hFF, 1'b0);
    send_item(OP_BYTE, 8'h01, 1'b0);
    send_item(OP_BYTE, 8'h00, 1'b0);
    send_item(OP_DRAIN, 8'h00, 1'b0);
    send_item(OP_BYTE, 8'hA5, 1'b1);
    repeat (3) send_item(OP_DRAIN, 8'hFF, 1'b0);
    // No literals and a match that reaches back to the first byte produced.
    send_item(OP_BYTE, 8'h03, 1'b0);
    send_item(OP_BYTE, out_count[7:0], 1'b0);
    send_item(OP_BYTE, 8'h00, 1'b0);
    repeat (7) send_item(OP_DRAIN, 8'h00, 1'b0);
  endtask

  task automatic test_extended_lengths();
    send_sequence(15, 19, 0);
    send_sequence(3, 4 + 15 + 255, 0);
  endtask

  task automatic test_random_traffic();
    int mark;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 67; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      mark = stream_items;
      while (stream_items - mark < 15) send_random_sequence(5);
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_output_backpressure();
    int mark;
    mark = stream_items;
    hold_left = 200;
    while (stream_items - mark < 16) send_random_sequence(0);
    wait_drained();
    mark = stream_items;
    while (stream_items - mark < 8) send_random_sequence(5);
  endtask

  // Only reset starts a new block, so the run ends with one way of stopping,
  // chosen at random, followed by a few transactions that must be rejected.
  task automatic test_block_termination();
    int kind;
    int cut;
    int avail;
    int lit_n;
    kind = $urandom_range(END_NORMAL, END_TRUNCATION);
    lit_n = $urandom_range(0, 5);
    if (out_count == 0 && lit_n == 0) lit_n = 1;
    avail = out_count + lit_n;
    case (kind)
      END_NORMAL: begin
        end_kind = "normal completion";
        build_sequence(lit_n, $urandom_range(4, 19), 0, 1'b0);
      end
      END_ZERO_DIST: begin
        end_kind = "zero offset";
        build_sequence(lit_n, $urandom_range(4, 18), 0, 1'b1);
      end
      END_FAR_DIST: begin
        end_kind = "offset beyond output";
        build_sequence(lit_n, $urandom_range(4, 18), $urandom_range(avail + 1, 65535), 1'b1);
      end
      default: begin
        end_kind = "truncation";
        build_sequence(lit_n, $urandom_range(4, 24), pick_distance(avail), 1'b1);
      end
    endcase
    cut = seq_bytes.size() - 1;
    if (kind == END_TRUNCATION) cut = $urandom_range(0, seq_bytes.size() - 1);
    for (int i = 0; i <= cut; i++)
      send_item(OP_BYTE, seq_bytes[i],
                (i == cut) && (kind == END_NORMAL || kind == END_TRUNCATION));
    send_item(OP_BYTE, 8'($urandom_range(0, 255)), 1'b0);
    send_item(OP_DRAIN, 8'($urandom_range(0, 255)), 1'b1);
    send_item(OP_BYTE, 8'($urandom_range(0, 255)), 1'b1);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      downstream.ready <= 1'b0;
    end else if (hold_left > 0) begin
      downstream.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      downstream.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : check_outputs
    dec_result_t want;
    if (!rst && downstream.valid && downstream.ready) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("output transaction with nothing expected");
      end else begin
        want = decoded_q.pop_front();
        if (want.out_valid) bytes_out++;
        flag_count[want.error_code]++;
        if (downstream.out_valid !== want.out_valid)
          report_mismatch($sformatf("out_valid %b, expected %b",
                                    downstream.out_valid, want.out_valid));
        if (downstream.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %h, expected %h",
                                    downstream.out_byte, want.out_byte));
        if (downstream.copy_pending !== want.copy_pending)
          report_mismatch($sformatf("copy_pending %b, expected %b",
                                    downstream.copy_pending, want.copy_pending));
        if (downstream.block_done !== want.block_done)
          report_mismatch($sformatf("block_done %b, expected %b",
                                    downstream.block_done, want.block_done));
        if (downstream.error_code !== want.error_code)
          report_mismatch($sformatf("error_code %0d, expected %0d",
                                    downstream.error_code, want.error_code));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, decoded_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    upstream.valid     = 1'b0;
    upstream.opcode    = OP_BYTE;
    upstream.in_byte   = 8'h00;
    upstream.block_end = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_extended_lengths();
    test_random_traffic();
    test_output_backpressure();
    test_block_termination();
    wait_drained();
    repeat (8) @(posedge clk);
    $display("decoded %0d sequence bytes and drains into %0d output bytes",
             stream_items, bytes_out);
    $display("flags seen: bad offset %0d, truncated %0d, unexpected %0d; block ended by %s",
             flag_count[ERR_BAD_OFFSET], flag_count[ERR_TRUNCATED],
             flag_count[ERR_UNEXPECTED], end_kind);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
